[src/tad_pkg.sv]
`timescale 1ns / 1ps

package tad_pkg;

   // Frame geometry limits fixed by the stream format.
   localparam int COL_W      = 12;
   localparam int POS_W      = 13;
   localparam int SIZE_W     = 7;
   localparam int START_W    = 14;
   localparam int MAX_WIDTH  = 4096;
   localparam logic [POS_W-1:0] FRAME_LIMIT = 13'd4096;

   // Pixel and accumulator widths.
   localparam int CHANNELS   = 4;
   localparam int SAMPLE_W   = 16;
   localparam int STORE_W    = 30;
   localparam int SUM_W      = 37;
   localparam int CNT_W      = 14;
   localparam int SPAN_W     = 8;
   localparam int ENABLE_W   = 4;

   // Iteration counts of the two sequential dividers.
   localparam int SYNC_STEPS = 13;
   localparam int DIV_STEPS  = 37;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd6;

   localparam int REQ_DATA_W = CHANNELS * SAMPLE_W;
   localparam int RSP_DATA_W = 120;

   // One covered pixel, classified by the front end.
   typedef struct packed {
      logic [COL_W-1:0]                   col;
      logic [CHANNELS-1:0][SAMPLE_W-1:0]  samples;
      logic [CHANNELS-1:0]                enable;
      logic                               first_row;
      logic                               emit;
      logic [COL_W-1:0]                   x1;
      logic [COL_W-1:0]                   y1;
      logic [POS_W-1:0]                   x2;
      logic [POS_W-1:0]                   y2;
   } tad_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tad_fifo_status_type;

   typedef enum logic [1:0] {
      FRONT_LOAD,
      FRONT_SYNC,
      FRONT_FIX,
      FRONT_RUN
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_WRITE,
      BACK_SUM,
      BACK_DRAIN,
      BACK_DIV,
      BACK_OUT
   } back_state_type;

endpackage

[src/tad_fifo.sv]
`timescale 1ns / 1ps

module tad_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tad_pkg::tad_item_type         push_item,
   input  logic                          pop,
   output tad_pkg::tad_item_type         head,
   output tad_pkg::tad_fifo_status_type  status
);
   import tad_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tad_item_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/tad_front.sv]
`timescale 1ns / 1ps

module tad_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [tad_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tad_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [tad_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic                                   req_tuser,
   input  tad_pkg::tad_fifo_status_type           fifo_status,
   output logic                                   push,
   output tad_pkg::tad_item_type                  push_item
);
   import tad_pkg::*;

   localparam int EXT_W = START_W - SIZE_W;

   // Configuration registers.
   logic [SIZE_W-1:0]   tile_width_ff, tile_height_ff, offset_x_ff, offset_y_ff;
   logic [ENABLE_W-1:0] channel_enable_ff;
   logic [POS_W-1:0]    frame_width_ff, frame_height_ff;

   // Position and current tile starts.
   logic [COL_W-1:0]          col_ff, col_in, row_ff, row_in;
   logic signed [START_W-1:0] xs_ff, xs_in, ys_ff, ys_in;

   // Resync divider.
   front_state_type     state_ff, state_in;
   logic [3:0]          sync_cnt_ff, sync_cnt_in;
   logic [POS_W-1:0]    div_x_ff, div_x_in, div_y_ff, div_y_in;
   logic [SIZE_W-1:0]   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;

   logic [SIZE_W-1:0]         tw, th;
   logic [POS_W-1:0]          fw, fh;
   logic signed [START_W-1:0] tw_s, th_s, fw_s, fh_s;
   logic signed [START_W-1:0] first_x, first_y, zero_x, zero_y;
   logic signed [START_W-1:0] col_s, row_s, dx, dy;
   logic [SIZE_W:0]           tx, ty, tx_sub, ty_sub;

   logic                      accept;
   logic [POS_W-1:0]          c_a, r_a, r_inc, c_n, r_n;
   logic signed [START_W-1:0] xs_a, ys_a, xe, ye;
   logic                      cov_x, cov_y;
   logic [COL_W-1:0]          x1, y1;
   logic [POS_W-1:0]          x2, y2;

   function automatic logic signed [START_W-1:0] step_start(
      input logic [POS_W-1:0]          pos,
      input logic signed [START_W-1:0] prev,
      input logic signed [START_W-1:0] first,
      input logic signed [START_W-1:0] size
   );
      logic signed [START_W-1:0] p;
      logic signed [START_W-1:0] nxt;
      p   = $signed({1'b0, pos});
      nxt = prev + size;
      if (p == first) begin
         return first;
      end else if (p == nxt) begin
         return nxt;
      end
      return prev;
   endfunction

   // Effective sizes: zero acts as one, frame sizes saturate at the limit.
   assign tw   = (tile_width_ff == '0) ? SIZE_W'(1) : tile_width_ff;
   assign th   = (tile_height_ff == '0) ? SIZE_W'(1) : tile_height_ff;
   assign fw   = (frame_width_ff == '0) ? POS_W'(1)
               : (frame_width_ff > FRAME_LIMIT) ? FRAME_LIMIT : frame_width_ff;
   assign fh   = (frame_height_ff == '0) ? POS_W'(1)
               : (frame_height_ff > FRAME_LIMIT) ? FRAME_LIMIT : frame_height_ff;
   assign tw_s = $signed({{EXT_W{1'b0}}, tw});
   assign th_s = $signed({{EXT_W{1'b0}}, th});
   assign fw_s = $signed({1'b0, fw});
   assign fh_s = $signed({1'b0, fh});

   assign first_x = $signed({{EXT_W{1'b0}}, offset_x_ff}) - tw_s;
   assign first_y = $signed({{EXT_W{1'b0}}, offset_y_ff}) - th_s;
   // Tile start seen at position zero: with no offset the grid lands on zero.
   assign zero_x  = (offset_x_ff == '0) ? '0 : first_x;
   assign zero_y  = (offset_y_ff == '0) ? '0 : first_y;

   // Resync: tile start = position - ((position - first) mod size).
   assign col_s  = $signed({2'b00, col_ff});
   assign row_s  = $signed({2'b00, row_ff});
   assign dx     = col_s - first_x;
   assign dy     = row_s - first_y;
   assign tx     = {rem_x_ff, div_x_ff[POS_W-1]};
   assign ty     = {rem_y_ff, div_y_ff[POS_W-1]};
   assign tx_sub = tx - {1'b0, tw};
   assign ty_sub = ty - {1'b0, th};

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == FRONT_RUN) && !fifo_status.full;

   // Position of the incoming pixel after start-of-frame and wrap handling.
   always_comb begin
      c_a   = {1'b0, col_ff};
      r_a   = {1'b0, row_ff};
      xs_a  = xs_ff;
      ys_a  = ys_ff;
      r_inc = '0;
      if (req_tuser) begin
         c_a  = '0;
         r_a  = '0;
         xs_a = zero_x;
         ys_a = zero_y;
      end
      if (c_a >= fw) begin
         r_inc = r_a + 1'b1;
         c_a   = '0;
         xs_a  = zero_x;
         r_a   = r_inc;
         ys_a  = step_start(r_inc, ys_a, first_y, th_s);
      end
      if (r_a >= fh) begin
         r_a  = '0;
         ys_a = zero_y;
      end
   end

   assign cov_x = $signed({1'b0, c_a}) >= first_x;
   assign cov_y = $signed({1'b0, r_a}) >= first_y;
   assign xe    = xs_a + tw_s;
   assign ye    = ys_a + th_s;
   assign x1    = xs_a[START_W-1] ? '0 : xs_a[COL_W-1:0];
   assign y1    = ys_a[START_W-1] ? '0 : ys_a[COL_W-1:0];
   assign x2    = (xe > fw_s) ? fw : xe[POS_W-1:0];
   assign y2    = (ye > fh_s) ? fh : ye[POS_W-1:0];
   assign c_n   = c_a + 1'b1;
   assign r_n   = r_a + 1'b1;

   always_comb begin
      push_item.col       = c_a[COL_W-1:0];
      push_item.samples   = req_tdata;
      push_item.enable    = channel_enable_ff;
      push_item.first_row = (r_a == {1'b0, y1});
      push_item.emit      = (c_a == x2 - 1'b1) && (r_a == y2 - 1'b1);
      push_item.x1        = x1;
      push_item.y1        = y1;
      push_item.x2        = x2;
      push_item.y2        = y2;
   end

   assign push = accept && cov_x && cov_y;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_LOAD: state_in = FRONT_SYNC;
         FRONT_SYNC: begin
            if (sync_cnt_ff == 4'(SYNC_STEPS - 1)) begin
               state_in = FRONT_FIX;
            end
         end
         FRONT_FIX:  state_in = FRONT_RUN;
         FRONT_RUN:  state_in = FRONT_RUN;
         default:    state_in = FRONT_LOAD;
      endcase
      if (csr_we) begin
         state_in = FRONT_LOAD;
      end
   end

   // Datapath updates per state.
   always_comb begin
      sync_cnt_in = sync_cnt_ff;
      div_x_in    = div_x_ff;
      div_y_in    = div_y_ff;
      rem_x_in    = rem_x_ff;
      rem_y_in    = rem_y_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      xs_in       = xs_ff;
      ys_in       = ys_ff;
      unique case (state_ff)
         FRONT_LOAD: begin
            sync_cnt_in = '0;
            div_x_in    = dx[START_W-1] ? '0 : dx[POS_W-1:0];
            div_y_in    = dy[START_W-1] ? '0 : dy[POS_W-1:0];
            rem_x_in    = '0;
            rem_y_in    = '0;
         end
         FRONT_SYNC: begin
            sync_cnt_in = sync_cnt_ff + 1'b1;
            div_x_in    = {div_x_ff[POS_W-2:0], 1'b0};
            div_y_in    = {div_y_ff[POS_W-2:0], 1'b0};
            rem_x_in    = (tx >= {1'b0, tw}) ? tx_sub[SIZE_W-1:0] : tx[SIZE_W-1:0];
            rem_y_in    = (ty >= {1'b0, th}) ? ty_sub[SIZE_W-1:0] : ty[SIZE_W-1:0];
         end
         FRONT_FIX: begin
            xs_in = (col_s >= first_x) ? col_s - $signed({{EXT_W{1'b0}}, rem_x_ff})
                                       : first_x;
            ys_in = (row_s >= first_y) ? row_s - $signed({{EXT_W{1'b0}}, rem_y_ff})
                                       : first_y;
         end
         FRONT_RUN: begin
            if (accept) begin
               if (c_n >= fw) begin
                  col_in = '0;
                  xs_in  = zero_x;
                  if (r_n >= fh) begin
                     row_in = '0;
                     ys_in  = zero_y;
                  end else begin
                     row_in = r_n[COL_W-1:0];
                     ys_in  = step_start(r_n, ys_a, first_y, th_s);
                  end
               end else begin
                  col_in = c_n[COL_W-1:0];
                  xs_in  = step_start(c_n, xs_a, first_x, tw_s);
                  row_in = r_a[COL_W-1:0];
                  ys_in  = ys_a;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= FRONT_LOAD;
         col_ff            <= '0;
         row_ff            <= '0;
         tile_width_ff     <= SIZE_W'(2);
         tile_height_ff    <= SIZE_W'(2);
         offset_x_ff       <= '0;
         offset_y_ff       <= '0;
         channel_enable_ff <= '1;
         frame_width_ff    <= POS_W'(1920);
         frame_height_ff   <= POS_W'(1080);
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TILE_WIDTH:     tile_width_ff     <= csr_wdata[SIZE_W-1:0];
               CSR_TILE_HEIGHT:    tile_height_ff    <= csr_wdata[SIZE_W-1:0];
               CSR_OFFSET_X:       offset_x_ff       <= csr_wdata[SIZE_W-1:0];
               CSR_OFFSET_Y:       offset_y_ff       <= csr_wdata[SIZE_W-1:0];
               CSR_CHANNEL_ENABLE: channel_enable_ff <= csr_wdata[ENABLE_W-1:0];
               CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[POS_W-1:0];
               CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[POS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sync_cnt_ff <= sync_cnt_in;
      div_x_ff    <= div_x_in;
      div_y_ff    <= div_y_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
   end

endmodule

[src/tad_back.sv]
`timescale 1ns / 1ps

module tad_back (
   input  logic                                clock,
   input  logic                                reset,
   input  tad_pkg::tad_fifo_status_type        fifo_status,
   input  tad_pkg::tad_item_type               head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tad_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import tad_pkg::*;

   localparam int WORD_W = CHANNELS * STORE_W;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int PAD_W  = RSP_DATA_W - 2 * COL_W - 2 * POS_W - CHANNELS * SAMPLE_W;

   // Column sum store, one word holds all channels.
   logic [WORD_W-1:0] store_mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;

   back_state_type    state_ff, state_in;
   tad_item_type      item_ff;
   logic [COL_W-1:0]  k_ff, k_in;
   logic              sum_vld_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [5:0]        div_cnt_ff, div_cnt_in;
   logic [SPAN_W-1:0] span_x, span_y;
   logic [2*SPAN_W-1:0] product;

   logic [CHANNELS-1:0][SUM_W-1:0] acc_ff, acc_in;
   logic [CHANNELS-1:0][SUM_W-1:0] quot_ff, quot_in;
   logic [CHANNELS-1:0][CNT_W-1:0] rem_ff, rem_in;
   logic [CHANNELS-1:0][CNT_W:0]   trial, trial_sub;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] avg;

   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              load_rsp;

   assign pop     = (state_ff == BACK_IDLE) && !fifo_status.empty;
   assign rd_addr = (state_ff == BACK_IDLE) ? head.col : k_ff;
   assign mem_we  = (state_ff == BACK_WRITE);
   assign span_x  = SPAN_W'(item_ff.x2 - {1'b0, item_ff.x1});
   assign span_y  = SPAN_W'(item_ff.y2 - {1'b0, item_ff.y1});
   assign product = span_x * span_y;
   assign load_rsp = (state_ff == BACK_OUT) && (!rsp_valid_ff || rsp_tready);

   // Read-modify-write of the column entry; disabled channels keep their value.
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         logic [STORE_W-1:0] old_val;
         logic [STORE_W-1:0] add_val;
         old_val = rd_data_ff[ch*STORE_W +: STORE_W];
         add_val = {{(STORE_W-SAMPLE_W){1'b0}}, item_ff.samples[ch]};
         if (!item_ff.enable[ch]) begin
            wr_data[ch*STORE_W +: STORE_W] = old_val;
         end else if (item_ff.first_row) begin
            wr_data[ch*STORE_W +: STORE_W] = add_val;
         end else begin
            wr_data[ch*STORE_W +: STORE_W] = old_val + add_val;
         end
      end
   end

   // Column accumulation and restoring division, channels in parallel.
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         acc_in[ch]    = acc_ff[ch];
         quot_in[ch]   = quot_ff[ch];
         rem_in[ch]    = rem_ff[ch];
         trial[ch]     = {rem_ff[ch], quot_ff[ch][SUM_W-1]};
         trial_sub[ch] = trial[ch] - {1'b0, count_ff};
         if (state_ff == BACK_WRITE) begin
            acc_in[ch] = '0;
         end else if (sum_vld_ff) begin
            acc_in[ch] = acc_ff[ch]
                       + {{(SUM_W-STORE_W){1'b0}}, rd_data_ff[ch*STORE_W +: STORE_W]};
         end
         if (state_ff == BACK_DRAIN) begin
            quot_in[ch] = acc_in[ch];
            rem_in[ch]  = '0;
         end else if (state_ff == BACK_DIV) begin
            if (trial[ch] >= {1'b0, count_ff}) begin
               rem_in[ch]  = trial_sub[ch][CNT_W-1:0];
               quot_in[ch] = {quot_ff[ch][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[ch]  = trial[ch][CNT_W-1:0];
               quot_in[ch] = {quot_ff[ch][SUM_W-2:0], 1'b0};
            end
         end
         avg[ch] = item_ff.enable[ch] ? quot_ff[ch][SAMPLE_W-1:0] : '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE:  if (!fifo_status.empty) state_in = BACK_WRITE;
         BACK_WRITE: state_in = item_ff.emit ? BACK_SUM : BACK_IDLE;
         BACK_SUM: begin
            if ({1'b0, k_ff} == item_ff.x2 - 1'b1) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: state_in = BACK_DIV;
         BACK_DIV: begin
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = BACK_OUT;
            end
         end
         BACK_OUT:   if (load_rsp) state_in = BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   // Counters per state.
   always_comb begin
      k_in       = k_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         BACK_WRITE: k_in = item_ff.x1;
         BACK_SUM:   k_in = k_ff + 1'b1;
         BACK_DRAIN: div_cnt_in = '0;
         BACK_DIV:   div_cnt_in = div_cnt_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[item_ff.col] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         sum_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sum_vld_ff <= (state_ff == BACK_SUM);
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head;
      end
      if (state_ff == BACK_WRITE) begin
         count_ff <= product[CNT_W-1:0];
      end
      k_ff       <= k_in;
      div_cnt_ff <= div_cnt_in;
      acc_ff     <= acc_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      if (load_rsp) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, avg[3], avg[2], avg[1], avg[0],
                         item_ff.y2, item_ff.x2, item_ff.y1, item_ff.x1};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A store update always follows the pop of its pixel.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WRITE) |-> ($past(state_ff) == BACK_IDLE))
      else $error("store update without a popped pixel");

   // The column sweep never runs past the tile's right edge.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_SUM) |-> ({1'b0, k_ff} < item_ff.x2))
      else $error("column sweep beyond tile end");

   // A finished tile never divides by an empty pixel count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_DIV || state_ff == BACK_OUT) |-> (count_ff != '0))
      else $error("tile pixel count is zero");

endmodule

[src/tile_average_downsampler.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// req      in         tvalid / tready    tdata: 4 x 16-bit samples, tuser: start of frame
// rsp      out        tvalid / tready    tdata: tile bounds and 4 x 16-bit averages
// csr      in         we (no wait)       index 3 bits, wdata 13 bits
//
// A covered pixel occupies the store side for a read and then a write back;
// pixels outside the tile grid pass through the front end only.
// On a tile's last pixel the store side then sweeps the column sums of the
// tile, runs a restoring division and loads the result register. After
// reset and after every configuration write the front end re-derives the tile
// position (load, resync division, fix) before it takes pixels.
// Reset is synchronous; the column sum store is not cleared, and its enabled
// channels are loaded on the first row of a strip before they are read.
module tile_average_downsampler #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,

   // Configuration writes, taken on any cycle with csr_we high.
   input  logic                                csr_we,
   input  logic [tad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tad_pkg::CSR_DATA_W-1:0]      csr_wdata,

   // Pixel input.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: chan0_in, chan1_in, chan2_in, chan3_in.
   input  logic [tad_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Bit 0: start_of_frame.
   input  logic                                req_tuser,

   // Tile results.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // From bit 0: tile_x_start, tile_y_start, tile_x_end, tile_y_end,
   // chan0_avg, chan1_avg, chan2_avg, chan3_avg, then zero padding.
   output logic [tad_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import tad_pkg::*;

   // The front end tracks the raster position and the tile that holds it,
   // and hands each covered pixel, already classified, to a short queue.
   // The back end owns the column sum store and produces the averages, so a
   // slow tile finish does not stall the pixel input until the queue fills.
   tad_item_type        push_item;
   tad_item_type        head;
   tad_fifo_status_type fifo_status;
   logic                push;
   logic                pop;

   tad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .fifo_status (fifo_status),
      .push        (push),
      .push_item   (push_item)
   );

   // Every transfer into the queue is one covered pixel in raster order.
   tad_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (fifo_status)
   );

   // The result register lets the back end finish the next tile while a
   // previous result still waits for its transfer.
   tad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
